/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the merge table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/kqm_pkg.sv */
// ----------------------------------------------------------------------------
// kqm_pkg
// Types, widths and constants shared by the merge table modules.
// ----------------------------------------------------------------------------
package kqm_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  localparam int ID_W        = 16;
  localparam int QTY_W       = 32;
  localparam int OUT_SLOT_W  = 5;
  localparam int OUT_COUNT_W = 6;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_DUMP  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic [1:0]              operation;
    logic [ID_W-1:0]         item_id;
    logic signed [QTY_W-1:0] item_qty;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]          out_id;
    logic signed [QTY_W-1:0]  out_qty;
    logic [OUT_SLOT_W-1:0]    out_slot;
    logic                     is_new;
    logic                     entry_valid;
    logic                     table_full;
    logic [OUT_COUNT_W-1:0]   entry_count;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic capture;
    logic match_en;
    logic apply;
    logic dump_emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic table_empty;
    logic dump_last;
  } status_t;

endpackage

/* rtl/kqm_in_if.sv */
// ----------------------------------------------------------------------------
// kqm_in_if
// Input channel of the merge table: one record or command per beat.
// ----------------------------------------------------------------------------
interface kqm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] item_id;
  logic signed [31:0] item_qty;

  modport source (output valid, output operation, output item_id, output item_qty,
                  input ready);
  modport sink   (input valid, input operation, input item_id, input item_qty,
                  output ready);
endinterface

/* rtl/kqm_out_if.sv */
// ----------------------------------------------------------------------------
// kqm_out_if
// Result channel of the merge table: one table entry report per beat.
// ----------------------------------------------------------------------------
interface kqm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_id;
  logic signed [31:0] out_qty;
  logic [4:0]  out_slot;
  logic        is_new;
  logic        entry_valid;
  logic        table_full;
  logic [5:0]  entry_count;
  logic        last;

  modport source (output valid, output out_id, output out_qty, output out_slot,
                  output is_new, output entry_valid, output table_full,
                  output entry_count, output last, input ready);
  modport sink   (input valid, input out_id, input out_qty, input out_slot,
                  input is_new, input entry_valid, input table_full,
                  input entry_count, input last, output ready);
endinterface

/* rtl/kqm_ctrl.sv */
// ----------------------------------------------------------------------------
// kqm_ctrl
// Sequencer for the merge table: accept, match, apply and dump steps.
// ----------------------------------------------------------------------------
module kqm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic [1:0]       item_op,
  input  kqm_pkg::status_t status,
  output logic             item_ready,
  output kqm_pkg::cmd_t    cmd
);

  kqm_pkg::state_t state;
  kqm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kqm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    cmd        = '0;
    case (state)
      kqm_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          case (kqm_pkg::op_t'(item_op))
            kqm_pkg::OP_ACCUM: state_next = kqm_pkg::ST_MATCH;
            kqm_pkg::OP_DUMP:  state_next = kqm_pkg::ST_DUMP;
            kqm_pkg::OP_CLEAR: state_next = kqm_pkg::ST_APPLY;
            default:           state_next = kqm_pkg::ST_IDLE;
          endcase
        end
      end
      kqm_pkg::ST_MATCH: begin
        cmd.match_en = 1'b1;
        state_next   = kqm_pkg::ST_APPLY;
      end
      kqm_pkg::ST_APPLY: begin
        if (status.out_free) begin
          cmd.apply  = 1'b1;
          state_next = kqm_pkg::ST_IDLE;
        end
      end
      kqm_pkg::ST_DUMP: begin
        if (status.out_free) begin
          cmd.dump_emit = 1'b1;
          if (status.table_empty || status.dump_last) begin
            state_next = kqm_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = kqm_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/kqm_dp.sv */
// ----------------------------------------------------------------------------
// kqm_dp
// Datapath: entry registers, parallel id match, quantity adder, result register.
// ----------------------------------------------------------------------------
module kqm_dp (
  input  logic              clk,
  input  logic              rst,
  input  kqm_pkg::item_t    item,
  input  kqm_pkg::cmd_t     cmd,
  input  logic              out_ready,
  output kqm_pkg::status_t  status,
  output logic              out_valid,
  output kqm_pkg::result_t  out_data
);

  logic [kqm_pkg::ID_W-1:0]    ids  [kqm_pkg::TABLE_DEPTH];
  logic [kqm_pkg::QTY_W-1:0]   qtys [kqm_pkg::TABLE_DEPTH];
  logic [kqm_pkg::COUNT_W-1:0] count;

  logic [1:0]                  op_r;
  logic [kqm_pkg::ID_W-1:0]    id_r;
  logic [kqm_pkg::QTY_W-1:0]   qty_r;
  logic                        hit_r;
  logic [kqm_pkg::SLOT_W-1:0]  slot_r;
  logic [kqm_pkg::SLOT_W-1:0]  dump_idx;

  logic                        hit;
  logic [kqm_pkg::SLOT_W-1:0]  hit_slot;
  logic [kqm_pkg::SLOT_W-1:0]  rd_addr;
  logic [kqm_pkg::ID_W-1:0]    rd_id;
  logic [kqm_pkg::QTY_W-1:0]   rd_qty;
  logic [kqm_pkg::QTY_W-1:0]   sum;
  logic                        full;
  logic [kqm_pkg::SLOT_W-1:0]  tail;
  logic [kqm_pkg::COUNT_W-1:0] count_inc;
  logic                        emit;
  kqm_pkg::result_t            res;

  // Ids in the table are distinct, so at most one entry matches and the
  // slot can be formed by OR-ing the indices of the matching entries.
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < kqm_pkg::TABLE_DEPTH; i++) begin
      if ((ids[i] == id_r) && (kqm_pkg::COUNT_W'(i) < count)) begin
        hit      = 1'b1;
        hit_slot = hit_slot | kqm_pkg::SLOT_W'(i);
      end
    end
  end

  assign rd_addr   = cmd.dump_emit ? dump_idx : slot_r;
  assign rd_id     = ids[rd_addr];
  assign rd_qty    = qtys[rd_addr];
  assign sum       = rd_qty + qty_r;
  assign full      = (count == kqm_pkg::COUNT_W'(kqm_pkg::TABLE_DEPTH));
  assign tail      = count[kqm_pkg::SLOT_W-1:0];
  assign count_inc = count + kqm_pkg::COUNT_W'(1);

  assign status.out_free    = !out_valid || out_ready;
  assign status.table_empty = (count == '0);
  assign status.dump_last   = ((kqm_pkg::COUNT_W'(dump_idx) + kqm_pkg::COUNT_W'(1)) == count);

  assign emit = cmd.apply || cmd.dump_emit;

  always_comb begin
    res      = '0;
    res.last = 1'b1;
    if (cmd.dump_emit) begin
      if (!status.table_empty) begin
        res.out_id      = rd_id;
        res.out_qty     = rd_qty;
        res.out_slot    = kqm_pkg::OUT_SLOT_W'(dump_idx);
        res.entry_valid = 1'b1;
        res.entry_count = kqm_pkg::OUT_COUNT_W'(count);
        res.last        = status.dump_last;
      end
    end else if (kqm_pkg::op_t'(op_r) == kqm_pkg::OP_ACCUM) begin
      res.out_id      = id_r;
      res.entry_count = kqm_pkg::OUT_COUNT_W'(count);
      if (hit_r) begin
        res.out_qty     = sum;
        res.out_slot    = kqm_pkg::OUT_SLOT_W'(slot_r);
        res.entry_valid = 1'b1;
      end else if (!full) begin
        res.out_qty     = qty_r;
        res.out_slot    = kqm_pkg::OUT_SLOT_W'(tail);
        res.is_new      = 1'b1;
        res.entry_valid = 1'b1;
        res.entry_count = kqm_pkg::OUT_COUNT_W'(count_inc);
      end else begin
        res.table_full  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= item.operation;
      id_r  <= item.item_id;
      qty_r <= item.item_qty;
    end
    if (cmd.match_en) begin
      hit_r  <= hit;
      slot_r <= hit_slot;
    end
    if (cmd.apply && (kqm_pkg::op_t'(op_r) == kqm_pkg::OP_ACCUM)) begin
      if (hit_r) begin
        qtys[slot_r] <= sum;
      end else if (!full) begin
        ids[tail]  <= id_r;
        qtys[tail] <= qty_r;
      end
    end
    if (emit) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dump_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        dump_idx <= '0;
      end else if (cmd.dump_emit) begin
        dump_idx <= dump_idx + kqm_pkg::SLOT_W'(1);
      end
      if (cmd.apply) begin
        if (kqm_pkg::op_t'(op_r) == kqm_pkg::OP_CLEAR) begin
          count <= '0;
        end else if (!hit_r && !full) begin
          count <= count_inc;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/keyed_quantity_merge_table.sv */
// Accumulate steps: accept, parallel id match, then add and write back.
// Clear steps: accept, then apply. Dump: accept, then one entry per cycle while
// the output is not stalled; a dump of an empty table gives its single beat.
// Each result is registered in the output register by its apply or dump step; a
// new item is accepted only in the idle state, once the last step has issued.
// Reset empties the table and the result register; entry contents are not cleared.
// ----------------------------------------------------------------------------
// keyed_quantity_merge_table
// Merges (id, quantity) records into a first-seen-order table, dumps it and clears it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_quantity_merge_table (
  input  logic      clk,
  input  logic      rst,
  kqm_in_if.sink    item,
  kqm_out_if.source result
);

  kqm_pkg::item_t   item_data;
  kqm_pkg::result_t res_data;
  kqm_pkg::cmd_t    cmd;
  kqm_pkg::status_t status;
  logic             item_ready;
  logic             res_valid;

  assign item_data.operation = item.operation;
  assign item_data.item_id   = item.item_id;
  assign item_data.item_qty  = item.item_qty;
  assign item.ready          = item_ready;

  kqm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_op    (item.operation),
    .status     (status),
    .item_ready (item_ready),
    .cmd        (cmd)
  );

  kqm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item_data),
    .cmd       (cmd),
    .out_ready (result.ready),
    .status    (status),
    .out_valid (res_valid),
    .out_data  (res_data)
  );

  assign result.valid       = res_valid;
  assign result.out_id      = res_data.out_id;
  assign result.out_qty     = res_data.out_qty;
  assign result.out_slot    = res_data.out_slot;
  assign result.is_new      = res_data.is_new;
  assign result.entry_valid = res_data.entry_valid;
  assign result.table_full  = res_data.table_full;
  assign result.entry_count = res_data.entry_count;
  assign result.last        = res_data.last;

  `ASSERT_IMPL(a_idle_no_work, clk, rst, item_ready, !(cmd.match_en || cmd.apply || cmd.dump_emit))
  `ASSERT_NEXT(a_apply_gives_beat, clk, rst, cmd.apply, res_valid)
  `ASSERT_IMPL(a_slot_in_range, clk, rst, res_valid && res_data.entry_valid,
               {1'b0, res_data.out_slot} < res_data.entry_count)
  `ASSERT_NEXT(a_dump_end_idle, clk, rst, cmd.dump_emit && status.dump_last, item_ready)

endmodule
